/* rtl/crc32_reflected_configurable_poly_unit_assert.svh */
// assertion macros used by the top level of the crc unit rtl
`ifndef CRC32_REFLECTED_CONFIGURABLE_POLY_UNIT_ASSERT_SVH
`define CRC32_REFLECTED_CONFIGURABLE_POLY_UNIT_ASSERT_SVH

// same-cycle implication, checked at every rising clock edge out of reset
`define CRC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked at every rising clock edge out of reset
`define CRC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/crc32rcp_pkg.sv */
// package with types, constants and the byte update function of the crc unit
package crc32rcp_pkg;

  localparam int unsigned CRC_W  = 32;
  localparam int unsigned BYTE_W = 8;

  localparam logic [CRC_W-1:0] CRC_INIT   = 32'hFFFF_FFFF;
  localparam logic [CRC_W-1:0] POLY_RESET = 32'hEDB8_8320;

  // control of the input register toward the later stages
  typedef struct packed {
    logic valid;
    logic last;
    logic advance;
  } crc_s1_ctl_t;

  // one byte of reflected crc: xor in the byte, then eight shift-and-xor steps
  function automatic logic [CRC_W-1:0] crc_byte_step(
    input logic [CRC_W-1:0]  crc,
    input logic [BYTE_W-1:0] data,
    input logic [CRC_W-1:0]  poly
  );
    logic [CRC_W-1:0] c;
    c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, data};
    for (int k = 0; k < BYTE_W; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ poly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

/* rtl/crc32rcp_in_stage.sv */
// input register of the crc unit with its handshake toward the sender
module crc32rcp_in_stage
  import crc32rcp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] in_data_byte,
  input  logic              in_last_byte,
  input  logic              out_load_ok,
  output crc_s1_ctl_t       s1_ctl,
  output logic [BYTE_W-1:0] s1_byte
);

  logic              s1_valid_r;
  logic              s1_valid_nxt;
  logic              s1_last_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              advance;
  logic              accept;

  // a held word moves on unless it is a last word and the output register is busy
  assign advance  = s1_valid_r && (!s1_last_r || out_load_ok);
  assign in_stall = s1_valid_r && !advance;
  assign accept   = in_valid && !in_stall;

  // occupancy of the input register
  always_comb begin
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_byte_r <= in_data_byte;
      s1_last_r <= in_last_byte;
    end
  end

  assign s1_ctl.valid   = s1_valid_r;
  assign s1_ctl.last    = s1_last_r;
  assign s1_ctl.advance = advance;
  assign s1_byte        = s1_byte_r;

endmodule

/* rtl/crc32rcp_core.sv */
// polynomial register, running crc register and the per-byte update logic
module crc32rcp_core
  import crc32rcp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [CRC_W-1:0]  cfg_wr_data,
  input  crc_s1_ctl_t       s1_ctl,
  input  logic [BYTE_W-1:0] s1_byte,
  output logic [CRC_W-1:0]  crc_next,
  output logic [CRC_W-1:0]  running_crc
);

  logic [CRC_W-1:0] poly_r;
  logic [CRC_W-1:0] crc_r;
  logic [CRC_W-1:0] crc_nxt;

  // polynomial register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_r <= POLY_RESET;
    end else if (cfg_wr_en) begin
      poly_r <= cfg_wr_data;
    end
  end

  // crc including the word in the input register
  assign crc_next = crc_byte_step(crc_r, s1_byte, poly_r);

  // running value restarts after the last word of a buffer
  always_comb begin
    if (s1_ctl.advance) begin
      crc_nxt = s1_ctl.last ? CRC_INIT : crc_next;
    end else begin
      crc_nxt = crc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= CRC_INIT;
    end else begin
      crc_r <= crc_nxt;
    end
  end

  assign running_crc = crc_r;

endmodule

/* rtl/crc32rcp_out_stage.sv */
// result register of the crc unit with its handshake toward the receiver
module crc32rcp_out_stage
  import crc32rcp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  crc_s1_ctl_t      s1_ctl,
  input  logic [CRC_W-1:0] crc_next,
  output logic             out_load_ok,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [CRC_W-1:0] out_crc_value
);

  logic             out_valid_r;
  logic             out_valid_nxt;
  logic [CRC_W-1:0] out_crc_r;
  logic             load;

  // free, or emptied by the receiver in this cycle
  assign out_load_ok = !out_valid_r || !out_stall;
  assign load        = s1_ctl.advance && s1_ctl.last;

  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // result capture
  always_ff @(posedge clk) begin
    if (load) begin
      out_crc_r <= crc_next;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_crc_value = out_crc_r;

endmodule

/* rtl/crc32_reflected_configurable_poly_unit.sv */
// top level of the reflected crc-32 unit with a programmable polynomial
//
// Input channel: in_valid / in_stall carry one byte word per handshake
// (in_data_byte, in_last_byte). Result channel: out_valid / out_stall carry
// out_crc_value, one word per buffer, given with the byte marked last; the
// value is the reflected crc over the buffer starting from all ones, with
// no final inversion.
// Configuration: cfg_wr_en writes cfg_wr_data into the polynomial register
// (reset value 0xEDB88320); write it only while no word is in flight.
// A last byte goes from the input register to the output register. One byte
// per cycle unless in_stall is raised; the eight shift-and-xor steps of a
// byte are combinational between the input and running crc registers.
// Reset: rst_n (synchronous) empties both registers, sets the running crc to
// all ones and the polynomial to its reset value.
// Stall: a finished crc waits in the output register while the next buffer
// keeps streaming; only a further last byte waits in the input register,
// which then raises in_stall until the result is taken.
module crc32_reflected_configurable_poly_unit
  import crc32rcp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [CRC_W-1:0]  cfg_wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] in_data_byte,
  input  logic              in_last_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CRC_W-1:0]  out_crc_value
);

`include "crc32_reflected_configurable_poly_unit_assert.svh"

  crc_s1_ctl_t       s1_ctl;
  logic [BYTE_W-1:0] s1_byte;
  logic              out_load_ok;
  logic [CRC_W-1:0]  crc_next;
  logic [CRC_W-1:0]  running_crc;

  // input register
  crc32rcp_in_stage u_in_stage (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .out_load_ok  (out_load_ok),
    .s1_ctl       (s1_ctl),
    .s1_byte      (s1_byte)
  );

  // crc update
  crc32rcp_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s1_ctl      (s1_ctl),
    .s1_byte     (s1_byte),
    .crc_next    (crc_next),
    .running_crc (running_crc)
  );

  // result register
  crc32rcp_out_stage u_out_stage (
    .clk           (clk),
    .rst_n         (rst_n),
    .s1_ctl        (s1_ctl),
    .crc_next      (crc_next),
    .out_load_ok   (out_load_ok),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_crc_value (out_crc_value)
  );

  // checks across the stages
  `CRC_ASSERT_NEXT(a_crc_restart, s1_ctl.advance && s1_ctl.last, running_crc == CRC_INIT, "running crc not restarted after last byte")
  `CRC_ASSERT_NOW(a_no_overwrite, s1_ctl.advance && s1_ctl.last, !out_valid || !out_stall, "pending crc overwritten")
  `CRC_ASSERT_NOW(a_stall_only_held, in_stall, s1_ctl.valid && s1_ctl.last, "stall without a held last byte")
  `CRC_ASSERT_NEXT(a_mid_byte_keeps_out, s1_ctl.advance && !s1_ctl.last && out_valid && out_stall, $stable(out_crc_value) && out_valid, "ordinary byte disturbed the result")
  `CRC_ASSERT_NOW(a_advance_needs_word, s1_ctl.advance, s1_ctl.valid, "advance from an empty input register")

endmodule

/* tb/tb.sv */
// testbench for the reflected crc-32 unit with a programmable polynomial
`timescale 1ns / 100ps

module tb;
  import crc32rcp_pkg::*;

  typedef struct {
    logic [BYTE_W-1:0] data;
    logic              last;
  } byte_word_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_wr_en = 1'b0;
  logic [CRC_W-1:0]  cfg_wr_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [BYTE_W-1:0] in_data_byte = '0;
  logic              in_last_byte = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [CRC_W-1:0]  out_crc_value;

  // words waiting to be sent, crcs waiting to come back
  byte_word_t       pending_words[$];
  logic [CRC_W-1:0] expected_crcs[$];

  // own copy of the unit state
  logic [CRC_W-1:0] buffer_crc = CRC_INIT;
  logic [CRC_W-1:0] crc_poly = POLY_RESET;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;

  crc32_reflected_configurable_poly_unit i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data_byte  (in_data_byte),
    .in_last_byte  (in_last_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_crc_value (out_crc_value)
  );

  // lsb-first crc update, one data bit per shift
  function automatic logic [CRC_W-1:0] crc_after_byte(
    input logic [CRC_W-1:0]  crc,
    input logic [BYTE_W-1:0] data,
    input logic [CRC_W-1:0]  poly
  );
    logic [CRC_W-1:0] r;
    logic             feedback;
    r = crc;
    for (int k = 0; k < BYTE_W; k++) begin
      feedback = r[0] ^ data[k];
      r = r >> 1;
      if (feedback) begin
        r = r ^ poly;
      end
    end
    return r;
  endfunction

  // clock
  initial begin
    forever #10 clk = ~clk;
  end

  // run limit
  initial begin
    #4_000_000;
    $display("tb: failure");
    $finish;
  end

  // driver: present the head of the pending queue, update the prediction on accept
  always @(posedge clk) begin : drive_words
    logic presenting;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      presenting = in_valid;
      if (in_valid && !in_stall) begin
        buffer_crc = crc_after_byte(buffer_crc, pending_words[0].data, crc_poly);
        if (pending_words[0].last) begin
          expected_crcs.push_back(buffer_crc);
          buffer_crc = CRC_INIT;
        end
        pending_words.pop_front();
        presenting = 1'b0;
      end
      if (!presenting && pending_words.size() != 0 &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        presenting = 1'b1;
      end
      in_valid <= presenting;
      if (presenting) begin
        in_data_byte <= pending_words[0].data;
        in_last_byte <= pending_words[0].last;
      end
    end
  end

  // monitor: compare each accepted crc with the oldest expectation
  always @(posedge clk) begin : check_crcs
    logic [CRC_W-1:0] want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_crcs.size() == 0) begin
          $display("%0t: unexpected crc word: expected none, actual %h",
                   $time, out_crc_value);
          mismatches++;
        end else begin
          want = expected_crcs.pop_front();
          if (out_crc_value !== want) begin
            $display("%0t: crc_value mismatch: expected %h, actual %h",
                     $time, want, out_crc_value);
            mismatches++;
          end
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // wait until every word is sent and every crc is back, then let the pipe drain
  task automatic drain;
    while (pending_words.size() != 0 || expected_crcs.size() != 0) begin
      @(negedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  // program the polynomial while the unit is idle
  task automatic write_poly(input logic [CRC_W-1:0] poly);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= poly;
    crc_poly = poly;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic add_word(input logic [BYTE_W-1:0] data, input logic last);
    byte_word_t w;
    w.data = data;
    w.last = last;
    pending_words.push_back(w);
  endtask

  // one phase of random buffers under a given polynomial and idling mix
  task automatic random_phase(input int idle_pct, input int stall_pct,
                              input logic [CRC_W-1:0] poly, input int n_words);
    int last_pct;
    write_poly(poly);
    @(negedge clk);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    last_pct = $urandom_range(5, 60);
    for (int i = 0; i < n_words; i++) begin
      add_word(BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 99) < last_pct);
    end
    drain();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extreme bytes, one-byte buffers, runs of ones, reset polynomial
    @(negedge clk);
    add_word(8'h00, 1'b1);
    add_word(8'hFF, 1'b1);
    add_word(8'h00, 1'b0);
    add_word(8'hFF, 1'b0);
    add_word(8'h55, 1'b0);
    add_word(8'hAA, 1'b1);
    add_word(8'h01, 1'b0);
    add_word(8'h80, 1'b1);
    add_word(8'hFF, 1'b0);
    add_word(8'hFF, 1'b0);
    add_word(8'hFF, 1'b0);
    add_word(8'hFF, 1'b0);
    add_word(8'hFF, 1'b1);
    // buffer left open so the next polynomial write lands mid-buffer
    add_word(8'h12, 1'b0);
    add_word(8'h34, 1'b0);
    drain();

    // random phases through several polynomials, extremes among them
    random_phase(0, 0, 32'h0000_0000, 200);
    random_phase(63, 0, 32'hFFFF_FFFF, 300);
    random_phase(0, 63, 32'h82F6_3B78, 300);
    random_phase(17, 17, $urandom, 300);
    random_phase(17, 17, 32'h8000_0000, 250);
    random_phase(0, 0, 32'h0000_0001, 125);
    random_phase(63, 63, POLY_RESET, 125);

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/crc32rcp_pkg.sv
rtl/crc32rcp_in_stage.sv
rtl/crc32rcp_core.sv
rtl/crc32rcp_out_stage.sv
rtl/crc32_reflected_configurable_poly_unit.sv
tb/tb.sv
